// ===== hw/rtl/tno_pkg.sv =====
// Package: telnet byte codes, parser and command types, reply byte tables.
`default_nettype none
package tno_pkg;

  localparam logic [7:0] B_IAC  = 8'hff;
  localparam logic [7:0] B_DO   = 8'hfd;
  localparam logic [7:0] B_WONT = 8'hfc;
  localparam logic [7:0] B_WILL = 8'hfb;
  localparam logic [7:0] B_DONT = 8'hfe;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] OPT_TT = 8'd24;
  localparam logic [7:0] OPT_WS = 8'd31;
  localparam logic [7:0] B_SEND = 8'd1;
  localparam logic [7:0] B_IS   = 8'd0;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [7:0] WIDTH_RESET  = 8'd80;
  localparam logic [7:0] HEIGHT_RESET = 8'd24;

  localparam int Q_PTR_W = 2;
  localparam int Q_DEPTH = 1 << Q_PTR_W;
  localparam int IDX_W   = 4;

  typedef enum logic [2:0] {
    MODE_DATA,
    MODE_VERB,
    MODE_OPT,
    MODE_SUB1,
    MODE_SUB2,
    MODE_SUB3
  } mode_t;

  typedef enum logic [2:0] {
    VERB_DO,
    VERB_DONT,
    VERB_WILL,
    VERB_WONT,
    VERB_SB,
    VERB_OTHER
  } verb_t;

  typedef enum logic [2:0] {
    CMD_DATA,
    CMD_WILL_TT,
    CMD_WILL_WS,
    CMD_WONT,
    CMD_TT_IS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] opt;
  } cmd_t;

  function automatic logic [IDX_W-1:0] cmd_last_idx(input cmd_kind_t kind);
    unique case (kind)
      CMD_DATA:    return IDX_W'(0);
      CMD_WILL_TT: return IDX_W'(2);
      CMD_WILL_WS: return IDX_W'(11);
      CMD_WONT:    return IDX_W'(2);
      CMD_TT_IS:   return IDX_W'(9);
      default:     return IDX_W'(0);
    endcase
  endfunction

  function automatic logic [7:0] cmd_byte(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                                          input logic [7:0] width,
                                          input logic [7:0] height);
    logic [7:0] b;
    b = 8'h00;
    unique case (cmd.kind)
      CMD_DATA: b = cmd.opt;
      CMD_WILL_TT, CMD_WONT: begin
        unique case (idx)
          IDX_W'(0): b = B_IAC;
          IDX_W'(1): b = (cmd.kind == CMD_WONT) ? B_WONT : B_WILL;
          default:   b = (cmd.kind == CMD_WONT) ? cmd.opt : OPT_TT;
        endcase
      end
      CMD_WILL_WS: begin
        unique case (idx)
          IDX_W'(0):  b = B_IAC;
          IDX_W'(1):  b = B_WILL;
          IDX_W'(2):  b = OPT_WS;
          IDX_W'(3):  b = B_IAC;
          IDX_W'(4):  b = B_SB;
          IDX_W'(5):  b = OPT_WS;
          IDX_W'(6):  b = 8'h00;
          IDX_W'(7):  b = width;
          IDX_W'(8):  b = 8'h00;
          IDX_W'(9):  b = height;
          IDX_W'(10): b = B_IAC;
          default:    b = B_SE;
        endcase
      end
      CMD_TT_IS: begin
        unique case (idx)
          IDX_W'(0): b = B_IAC;
          IDX_W'(1): b = B_SB;
          IDX_W'(2): b = OPT_TT;
          IDX_W'(3): b = B_IS;
          IDX_W'(4): b = 8'h41;
          IDX_W'(5): b = 8'h4e;
          IDX_W'(6): b = 8'h53;
          IDX_W'(7): b = 8'h49;
          IDX_W'(8): b = B_IAC;
          default:   b = B_SE;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tno_if.sv =====
// Interfaces: received byte channel and result byte channel.
`default_nettype none
interface tno_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tno_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_dest;
  logic       last;
  modport source (output valid, output out_byte, output out_dest, output last, input ready);
  modport sink   (input valid, input out_byte, input out_dest, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/telnet_option_negotiator.sv =====
// Top level: telnet option negotiator, receive side.
//
//   channel  dir  handshake      payload
//   rx       in   valid/ready    rx_byte[7:0]
//   result   out  valid/ready    out_byte[7:0], out_dest, last
//   cfg      in   cfg_we         cfg_index[0], cfg_data[7:0]
//
// One received byte is taken per cycle while the four-entry command queue has room.
// Each command drains at one result word per cycle from the sequencer while result is ready:
// 1 word for data, 3 for WILL/WONT, 12 for the window-size report, 10 for the terminal type.
// A taken byte's first result word is registered in a queue slot, then in the output register.
// Synchronous reset clears parser, queue and output valid; sizes return to 80x24.
// A stalled result holds its word; the queue absorbs input until full.
`default_nettype none
module telnet_option_negotiator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  tno_rx_if.sink                               rx,
  tno_result_if.source                         result,
  input  wire logic                            cfg_we,
  input  wire logic [tno_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data
);
  import tno_pkg::*;

  cmd_t push_cmd;
  logic push_valid;
  logic push_ready;
  cmd_t head_cmd;
  logic head_valid;
  logic pop;

  tno_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  tno_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop)
  );

  tno_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/tno_front.sv =====
// Front end: parse received bytes and issue data and reply commands.
`default_nettype none
module tno_front (
  input  wire logic          clk,
  input  wire logic          rst,
  tno_rx_if.sink             rx,
  output tno_pkg::cmd_t      push_cmd,
  output logic               push_valid,
  input  wire logic          push_ready
);
  import tno_pkg::*;

  mode_t mode, mode_next;
  verb_t verb, verb_next;
  logic  match, match_next;
  logic  push;
  logic  accept;

  assign rx.ready   = push_ready;
  assign accept     = rx.valid && push_ready;
  assign push_valid = accept && push;

  always_comb begin
    mode_next     = mode;
    verb_next     = verb;
    match_next    = match;
    push          = 1'b0;
    push_cmd.kind = CMD_DATA;
    push_cmd.opt  = rx.rx_byte;
    unique case (mode)
      MODE_VERB: begin
        priority if (rx.rx_byte == B_DO) verb_next = VERB_DO;
        else if (rx.rx_byte == B_DONT) verb_next = VERB_DONT;
        else if (rx.rx_byte == B_WILL) verb_next = VERB_WILL;
        else if (rx.rx_byte == B_WONT) verb_next = VERB_WONT;
        else if (rx.rx_byte == B_SB) verb_next = VERB_SB;
        else verb_next = VERB_OTHER;
        mode_next = MODE_OPT;
      end
      MODE_OPT: begin
        mode_next = MODE_DATA;
        priority if (verb == VERB_DO) begin
          push = 1'b1;
          priority if (rx.rx_byte == OPT_TT) push_cmd.kind = CMD_WILL_TT;
          else if (rx.rx_byte == OPT_WS) push_cmd.kind = CMD_WILL_WS;
          else push_cmd.kind = CMD_WONT;
        end else if (verb == VERB_DONT) begin
          push          = 1'b1;
          push_cmd.kind = CMD_WONT;
        end else if (verb == VERB_SB && rx.rx_byte == OPT_TT) begin
          mode_next  = MODE_SUB1;
          match_next = 1'b1;
        end else begin
          mode_next = MODE_DATA;
        end
      end
      MODE_SUB1: begin
        match_next = match && (rx.rx_byte == B_SEND);
        mode_next  = MODE_SUB2;
      end
      MODE_SUB2: begin
        match_next = match && (rx.rx_byte == B_IAC);
        mode_next  = MODE_SUB3;
      end
      MODE_SUB3: begin
        mode_next     = MODE_DATA;
        match_next    = 1'b0;
        push          = match && (rx.rx_byte == B_SE);
        push_cmd.kind = CMD_TT_IS;
      end
      MODE_DATA: begin
        if (rx.rx_byte == B_IAC) begin
          mode_next = MODE_VERB;
        end else begin
          push = 1'b1;
        end
      end
      default: mode_next = MODE_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_DATA;
      verb  <= VERB_DO;
      match <= 1'b0;
    end else if (accept) begin
      mode  <= mode_next;
      verb  <= verb_next;
      match <= match_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tno_queue.sv =====
// Command queue between the parser and the reply sequencer.
`default_nettype none
module tno_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tno_pkg::cmd_t push_cmd,
  input  wire logic          push_valid,
  output logic               push_ready,
  output tno_pkg::cmd_t      head_cmd,
  output logic               head_valid,
  input  wire logic          pop
);
  import tno_pkg::*;

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               do_pop;

  assign push_ready = count != (Q_PTR_W + 1)'(Q_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push_valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tno_back.sv =====
// Back end: expand queued commands into result words, hold window size registers.
`default_nettype none
module tno_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tno_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [7:0]                       cfg_data,
  input  wire tno_pkg::cmd_t                    head_cmd,
  input  wire logic                             head_valid,
  output logic                                  pop,
  tno_result_if.source                          result
);
  import tno_pkg::*;

  logic [7:0]       display_width;
  logic [7:0]       display_height;
  logic [IDX_W-1:0] idx;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_dest;
  logic             out_last;
  logic             load;
  logic             emit;
  logic             at_end;

  assign load   = !out_valid || result.ready;
  assign emit   = load && head_valid;
  assign at_end = idx == cmd_last_idx(head_cmd.kind);
  assign pop    = emit && at_end;

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.out_dest = out_dest;
  assign result.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width  <= WIDTH_RESET;
      display_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  display_width  <= cfg_data;
        REG_HEIGHT: display_height <= cfg_data;
        default:    display_width  <= display_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) out_valid <= head_valid;
      if (emit) idx <= at_end ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= cmd_byte(head_cmd, idx, display_width, display_height);
      out_dest <= head_cmd.kind != CMD_DATA;
      out_last <= at_end;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tno_checker.sv =====
// Checker: port-level properties of the negotiator and its bind.
`default_nettype none
module tno_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_dest,
  input wire logic       out_last
);
  import tno_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_dest)
                                && $stable(out_last))
    else $error("stalled result word changed");

  a_display_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_dest |-> out_last)
    else $error("display word not marked last");

  a_no_iac_display: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_dest |-> out_byte != B_IAC)
    else $error("IAC passed to display");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_reply_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last ##1 out_valid && out_dest |-> out_byte == B_IAC)
    else $error("reply does not open with IAC");
endmodule

bind telnet_option_negotiator tno_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_byte  (result.out_byte),
  .out_dest  (result.out_dest),
  .out_last  (result.last)
);
`default_nettype wire
